/* hw/rtl/kirsch_northwest_edge_filter_core_assert.svh */
// Assertion macros for the Kirsch northwest edge filter core.
// Taken in by the RTL files that carry concurrent assertions; no dependencies.
`ifndef KIRSCH_NORTHWEST_EDGE_FILTER_CORE_ASSERT_SVH
`define KIRSCH_NORTHWEST_EDGE_FILTER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, switched off while reset is asserted.
`define KNEF_ASSERT_IMPL(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);
// Next-cycle implication, switched off while reset is asserted.
`define KNEF_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);
`else
`define KNEF_ASSERT_IMPL(label, clk, rst_n, cond, prop, msg)
`define KNEF_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg)
`endif
`endif

/* hw/rtl/knef_pkg.sv */
// Shared constants, types and helper functions of the Kirsch northwest edge filter.
// No dependencies.
`timescale 1ns / 1ps

package knef_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 4096;

    localparam int CH_W  = 8;
    localparam int PIX_W = 3 * CH_W;
    localparam int LINE_W = 2 * PIX_W;

    localparam int CFG_WIDTH_W  = 12;
    localparam int CFG_HEIGHT_W = 13;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 13;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int WEFF_W = $clog2(MAX_WIDTH + 1);
    localparam int HEFF_W = $clog2(MAX_HEIGHT + 1);
    localparam int FILL_W = $clog2(MAX_WIDTH + 2);

    localparam int SUM_POS_W = 10;
    localparam int SUM_NEG_W = 11;
    localparam int PROD_W    = 12;
    localparam int DIFF_W    = PROD_W + 1;

    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam int CRED_W     = FIFO_CNT_W + 1;

    localparam logic [CFG_IDX_W-1:0]    REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0]    REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RESET      = 12'd640;
    localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RESET     = 13'd480;
    localparam logic [CH_W-1:0]         CLAMP_MAX        = 8'hFF;

    typedef logic [PIX_W-1:0] t_pix;

    // Border handling and frame position of one result.
    typedef struct packed {
        logic top;
        logic bot;
        logic lc;
        logic rc;
        logic last;
    } t_border;

    typedef struct packed {
        logic [CH_W-1:0] edge_red;
        logic [CH_W-1:0] edge_green;
        logic [CH_W-1:0] edge_blue;
        logic            frame_last;
    } t_result;

    // A width of zero acts as one, anything above the line store as its depth.
    function automatic logic [WEFF_W-1:0] eff_width(input logic [CFG_WIDTH_W-1:0] v);
        logic [31:0] wide;
        wide = 32'(v);
        if (v == '0) return WEFF_W'(1);
        else if (wide > 32'(MAX_WIDTH)) return WEFF_W'(MAX_WIDTH);
        else return WEFF_W'(v);
    endfunction

    function automatic logic [HEFF_W-1:0] eff_height(input logic [CFG_HEIGHT_W-1:0] v);
        logic [31:0] wide;
        wide = 32'(v);
        if (v == '0) return HEFF_W'(1);
        else if (wide > 32'(MAX_HEIGHT)) return HEFF_W'(MAX_HEIGHT);
        else return HEFF_W'(v);
    endfunction

endpackage

/* hw/rtl/knef_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with registered data.
// A read of the address written in the same cycle returns the old contents. No dependencies.
`timescale 1ns / 1ps

module knef_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hw/rtl/kirsch_northwest_edge_filter_core.sv */
// Kirsch northwest 3x3 edge filter core; uses knef_pkg, knef_ram and the assert header.
// Throughput: one item per cycle while the result queue has room, set by the single line store RAM
// (one read, one write a cycle). A result is offered once the item that completes it has passed
// the pipeline registers into the result queue; that item comes one line plus one item after the pixel
// at the centre of the neighbourhood. Reset (synchronous, active low) clears positions, counters,
// window and result queue; the line stores are not cleared and need no clearing pass.
`timescale 1ns / 1ps
`include "kirsch_northwest_edge_filter_core_assert.svh"

module kirsch_northwest_edge_filter_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Configuration write channel.
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [knef_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [knef_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // Pixel input channel.
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [knef_pkg::CH_W-1:0]          i_pix_red,
    input  logic [knef_pkg::CH_W-1:0]          i_pix_green,
    input  logic [knef_pkg::CH_W-1:0]          i_pix_blue,
    input  logic                               i_drain,
    // Result channel.
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [knef_pkg::CH_W-1:0]          o_edge_red,
    output logic [knef_pkg::CH_W-1:0]          o_edge_green,
    output logic [knef_pkg::CH_W-1:0]          o_edge_blue,
    output logic                               o_frame_last
);

    // ------------------------------------------------------------------
    // Configuration registers. Writes are taken every cycle; the block
    // relies on them arriving only while it is idle.
    // ------------------------------------------------------------------
    logic [knef_pkg::CFG_WIDTH_W-1:0]  r_cfg_width;
    logic [knef_pkg::CFG_HEIGHT_W-1:0] r_cfg_height;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= knef_pkg::WIDTH_RESET;
            r_cfg_height <= knef_pkg::HEIGHT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                knef_pkg::REG_IMAGE_WIDTH: begin
                    r_cfg_width <= i_cfg_data[knef_pkg::CFG_WIDTH_W-1:0];
                end
                knef_pkg::REG_IMAGE_HEIGHT: begin
                    r_cfg_height <= i_cfg_data[knef_pkg::CFG_HEIGHT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    logic [knef_pkg::WEFF_W-1:0] w_eff;
    logic [knef_pkg::HEFF_W-1:0] h_eff;

    assign w_eff = knef_pkg::eff_width(r_cfg_width);
    assign h_eff = knef_pkg::eff_height(r_cfg_height);

    // ------------------------------------------------------------------
    // Position and flush control. All decisions for an item are made in
    // the cycle in which it is accepted; the work on the data follows in
    // the pipeline stages below.
    // ------------------------------------------------------------------
    logic [knef_pkg::COL_W-1:0]  r_in_col,  n_in_col;
    logic [knef_pkg::ROW_W-1:0]  r_in_row,  n_in_row;
    logic [knef_pkg::COL_W-1:0]  r_out_col, n_out_col;
    logic [knef_pkg::ROW_W-1:0]  r_out_row, n_out_row;
    logic [knef_pkg::FILL_W-1:0] r_fill,    n_fill;
    logic                        r_flushing, n_flushing;

    logic                        accept;
    logic                        ignore;
    logic                        restart_in;
    logic                        step;
    logic [knef_pkg::COL_W-1:0]  cur_in_col;
    logic [knef_pkg::ROW_W-1:0]  cur_in_row;
    logic [knef_pkg::COL_W-1:0]  cur_out_col;
    logic [knef_pkg::ROW_W-1:0]  cur_out_row;
    logic [knef_pkg::FILL_W-1:0] cur_fill;
    logic                        in_col_wrap;
    logic                        in_row_wrap;
    logic                        emit;
    logic                        flush_done;
    knef_pkg::t_border           brd;
    knef_pkg::t_pix              in_px;

    assign accept = i_in_valid && o_in_ready;

    // A drain only counts when it opens a flush at the start of a frame with
    // something pending, or continues a flush already under way.
    assign ignore = i_drain && !r_flushing &&
                    ((r_in_col != '0) || (r_in_row != '0) || (r_fill == '0));

    // A pixel arriving during a flush abandons it and starts a fresh frame.
    assign restart_in = !i_drain && r_flushing;
    assign step       = accept && !ignore;

    assign cur_in_col  = restart_in ? '0 : r_in_col;
    assign cur_in_row  = restart_in ? '0 : r_in_row;
    assign cur_out_col = restart_in ? '0 : r_out_col;
    assign cur_out_row = restart_in ? '0 : r_out_row;
    assign cur_fill    = restart_in ? '0 : r_fill;

    // Drains enter the window as black pixels and leave the stores alone.
    assign in_px = i_drain ? '0 : {i_pix_blue, i_pix_green, i_pix_red};

    assign in_col_wrap = (knef_pkg::WEFF_W'(cur_in_col) + 1'b1) >= w_eff;
    assign in_row_wrap = (knef_pkg::HEFF_W'(cur_in_row) + 1'b1) >= h_eff;

    // Results start once a full line plus one item has gone in.
    assign emit = cur_fill >= (knef_pkg::FILL_W'(w_eff) + 1'b1);

    assign brd.top  = (cur_out_row == '0);
    assign brd.bot  = (knef_pkg::HEFF_W'(cur_out_row) + 1'b1) >= h_eff;
    assign brd.lc   = (cur_out_col == '0);
    assign brd.rc   = (knef_pkg::WEFF_W'(cur_out_col) + 1'b1) >= w_eff;
    assign brd.last = brd.bot && brd.rc;

    // During a flush every step is a drain, so the last result ends it.
    assign flush_done = emit && i_drain && brd.last;

    always_comb begin
        n_in_col   = r_in_col;
        n_in_row   = r_in_row;
        n_out_col  = r_out_col;
        n_out_row  = r_out_row;
        n_fill     = r_fill;
        n_flushing = r_flushing;
        if (step) begin
            n_flushing = i_drain;
            n_in_col   = in_col_wrap ? '0 : cur_in_col + 1'b1;
            n_in_row   = cur_in_row;
            if (in_col_wrap) begin
                n_in_row = in_row_wrap ? '0 : cur_in_row + 1'b1;
            end
            n_out_col = cur_out_col;
            n_out_row = cur_out_row;
            n_fill    = cur_fill;
            if (emit) begin
                n_out_col = brd.rc ? '0 : cur_out_col + 1'b1;
                if (brd.rc) begin
                    n_out_row = brd.bot ? '0 : cur_out_row + 1'b1;
                end
            end else begin
                n_fill = cur_fill + 1'b1;
            end
            if (flush_done) begin
                n_in_col   = '0;
                n_in_row   = '0;
                n_out_col  = '0;
                n_out_row  = '0;
                n_fill     = '0;
                n_flushing = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_fill     <= '0;
            r_flushing <= 1'b0;
        end else begin
            r_in_col   <= n_in_col;
            r_in_row   <= n_in_row;
            r_out_col  <= n_out_col;
            r_out_row  <= n_out_row;
            r_fill     <= n_fill;
            r_flushing <= n_flushing;
        end
    end

    // ------------------------------------------------------------------
    // Line stores. Both lines share one RAM word: the upper line in the
    // high half, the middle line in the low half. The read is issued as
    // the item is accepted; the next cycle the data comes back, the column
    // is shifted into the window and the rolled column is written back.
    // ------------------------------------------------------------------
    logic                        r_b_valid;
    logic                        r_b_we;
    logic                        r_b_emit;
    logic [knef_pkg::COL_W-1:0]  r_b_col;
    knef_pkg::t_pix              r_b_px;
    knef_pkg::t_border           r_b_brd;
    logic                        r_b_fwd;
    knef_pkg::t_pix              r_fwd_up;
    knef_pkg::t_pix              r_fwd_mid;

    logic [knef_pkg::LINE_W-1:0] ram_q;
    knef_pkg::t_pix              b_up;
    knef_pkg::t_pix              b_mid;
    logic                        b_wr_en;
    logic                        fwd_hit;

    knef_ram #(
        .WIDTH (knef_pkg::LINE_W),
        .DEPTH (knef_pkg::MAX_WIDTH)
    ) u_line_ram (
        .i_clk     (i_clk),
        .i_wr_en   (b_wr_en),
        .i_wr_addr (r_b_col),
        .i_wr_data ({b_mid, r_b_px}),
        .i_rd_en   (step),
        .i_rd_addr (cur_in_col),
        .o_rd_data (ram_q)
    );

    assign b_wr_en = r_b_valid && r_b_we;

    // With one pixel per line two items in a row use the same column: the
    // read of the second misses the write of the first, which is forwarded.
    assign fwd_hit = step && b_wr_en && (r_b_col == cur_in_col);

    assign b_up  = r_b_fwd ? r_fwd_up  : ram_q[knef_pkg::LINE_W-1:knef_pkg::PIX_W];
    assign b_mid = r_b_fwd ? r_fwd_mid : ram_q[knef_pkg::PIX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_b_fwd   <= 1'b0;
        end else begin
            r_b_valid <= step;
            r_b_fwd   <= fwd_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_we    <= !i_drain;
        r_b_emit  <= emit;
        r_b_col   <= cur_in_col;
        r_b_px    <= in_px;
        r_b_brd   <= brd;
        r_fwd_up  <= b_mid;
        r_fwd_mid <= r_b_px;
    end

    // ------------------------------------------------------------------
    // Neighbourhood window: three rows by three columns, column two newest.
    // ------------------------------------------------------------------
    knef_pkg::t_pix r_win [3][3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_win[r][c] <= '0;
                end
            end
        end else if (r_b_valid) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r][0] <= r_win[r][1];
                r_win[r][1] <= r_win[r][2];
            end
            r_win[0][2] <= b_up;
            r_win[1][2] <= b_mid;
            r_win[2][2] <= r_b_px;
        end
    end

    // ------------------------------------------------------------------
    // Border replication and channel sums. The window holds this item's
    // neighbourhood in this cycle.
    // ------------------------------------------------------------------
    logic              r_c_valid;
    knef_pkg::t_border r_c_brd;
    knef_pkg::t_pix    rsel [3][3];
    knef_pkg::t_pix    nb   [3][3];
    logic [knef_pkg::SUM_POS_W-1:0] c_pos [3];
    logic [knef_pkg::SUM_NEG_W-1:0] c_neg [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            rsel[0][c] = r_c_brd.top ? r_win[1][c] : r_win[0][c];
            rsel[1][c] = r_win[1][c];
            rsel[2][c] = r_c_brd.bot ? r_win[1][c] : r_win[2][c];
        end
        for (int r = 0; r < 3; r++) begin
            nb[r][0] = r_c_brd.lc ? rsel[r][1] : rsel[r][0];
            nb[r][1] = rsel[r][1];
            nb[r][2] = r_c_brd.rc ? rsel[r][1] : rsel[r][2];
        end
        // Upper-left, up and left weigh +5; upper-right, right and the lower row weigh -3.
        for (int k = 0; k < 3; k++) begin
            c_pos[k] = knef_pkg::SUM_POS_W'(nb[0][0][k*knef_pkg::CH_W +: knef_pkg::CH_W])
                     + knef_pkg::SUM_POS_W'(nb[0][1][k*knef_pkg::CH_W +: knef_pkg::CH_W])
                     + knef_pkg::SUM_POS_W'(nb[1][0][k*knef_pkg::CH_W +: knef_pkg::CH_W]);
            c_neg[k] = knef_pkg::SUM_NEG_W'(nb[0][2][k*knef_pkg::CH_W +: knef_pkg::CH_W])
                     + knef_pkg::SUM_NEG_W'(nb[1][2][k*knef_pkg::CH_W +: knef_pkg::CH_W])
                     + knef_pkg::SUM_NEG_W'(nb[2][0][k*knef_pkg::CH_W +: knef_pkg::CH_W])
                     + knef_pkg::SUM_NEG_W'(nb[2][1][k*knef_pkg::CH_W +: knef_pkg::CH_W])
                     + knef_pkg::SUM_NEG_W'(nb[2][2][k*knef_pkg::CH_W +: knef_pkg::CH_W]);
        end
    end

    // ------------------------------------------------------------------
    // Weighting and clamp: 5*pos - 3*neg as shift and add, clamped to
    // the byte range, then pushed into the result queue.
    // ------------------------------------------------------------------
    logic                           r_d_valid;
    logic                           r_d_last;
    logic [knef_pkg::SUM_POS_W-1:0] r_d_pos [3];
    logic [knef_pkg::SUM_NEG_W-1:0] r_d_neg [3];
    logic [knef_pkg::CH_W-1:0]      d_edge  [3];
    knef_pkg::t_result              d_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else begin
            r_c_valid <= r_b_valid && r_b_emit;
            r_d_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c_brd  <= r_b_brd;
        r_d_last <= r_c_brd.last;
        for (int k = 0; k < 3; k++) begin
            r_d_pos[k] <= c_pos[k];
            r_d_neg[k] <= c_neg[k];
        end
    end

    always_comb begin
        logic [knef_pkg::PROD_W-1:0]        p5;
        logic [knef_pkg::PROD_W-1:0]        n3;
        logic signed [knef_pkg::DIFF_W-1:0] diff;
        for (int k = 0; k < 3; k++) begin
            p5   = knef_pkg::PROD_W'({r_d_pos[k], 2'b00}) + knef_pkg::PROD_W'(r_d_pos[k]);
            n3   = knef_pkg::PROD_W'({r_d_neg[k], 1'b0}) + knef_pkg::PROD_W'(r_d_neg[k]);
            diff = $signed({1'b0, p5}) - $signed({1'b0, n3});
            if (diff[knef_pkg::DIFF_W-1]) begin
                d_edge[k] = '0;
            end else if (diff[knef_pkg::PROD_W-1:knef_pkg::CH_W] != '0) begin
                d_edge[k] = knef_pkg::CLAMP_MAX;
            end else begin
                d_edge[k] = diff[knef_pkg::CH_W-1:0];
            end
        end
        d_res.edge_red   = d_edge[0];
        d_res.edge_green = d_edge[1];
        d_res.edge_blue  = d_edge[2];
        d_res.frame_last = r_d_last;
    end

    // ------------------------------------------------------------------
    // Result queue. It parts the pipeline from the consumer: the input is
    // ready while the queue has room for every result still in flight, so
    // the pipeline itself never stalls.
    // ------------------------------------------------------------------
    knef_pkg::t_result                r_fifo [knef_pkg::FIFO_DEPTH];
    logic [knef_pkg::FIFO_PTR_W-1:0]  r_wr_ptr;
    logic [knef_pkg::FIFO_PTR_W-1:0]  r_rd_ptr;
    logic [knef_pkg::FIFO_CNT_W-1:0]  r_fifo_cnt;
    logic                             fifo_push;
    logic                             fifo_pop;
    logic [1:0]                       pend;
    logic [knef_pkg::CRED_W-1:0]      credit_used;

    assign fifo_push = r_d_valid;
    assign fifo_pop  = o_out_valid && i_out_ready;

    assign pend = {1'b0, r_b_valid && r_b_emit} + {1'b0, r_c_valid} + {1'b0, r_d_valid};
    assign credit_used = knef_pkg::CRED_W'(r_fifo_cnt) + knef_pkg::CRED_W'(pend);
    assign o_in_ready  = credit_used < knef_pkg::CRED_W'(knef_pkg::FIFO_DEPTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_fifo_cnt <= '0;
        end else begin
            if (fifo_push) begin
                r_wr_ptr <= (r_wr_ptr == knef_pkg::FIFO_PTR_W'(knef_pkg::FIFO_DEPTH - 1)) ?
                            '0 : r_wr_ptr + 1'b1;
            end
            if (fifo_pop) begin
                r_rd_ptr <= (r_rd_ptr == knef_pkg::FIFO_PTR_W'(knef_pkg::FIFO_DEPTH - 1)) ?
                            '0 : r_rd_ptr + 1'b1;
            end
            priority if (fifo_push && !fifo_pop) begin
                r_fifo_cnt <= r_fifo_cnt + 1'b1;
            end else if (fifo_pop && !fifo_push) begin
                r_fifo_cnt <= r_fifo_cnt - 1'b1;
            end else begin
                r_fifo_cnt <= r_fifo_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fifo_push) begin
            r_fifo[r_wr_ptr] <= d_res;
        end
    end

    assign o_out_valid  = (r_fifo_cnt != '0);
    assign o_edge_red   = r_fifo[r_rd_ptr].edge_red;
    assign o_edge_green = r_fifo[r_rd_ptr].edge_green;
    assign o_edge_blue  = r_fifo[r_rd_ptr].edge_blue;
    assign o_frame_last = r_fifo[r_rd_ptr].frame_last;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `KNEF_ASSERT_IMPL(a_queue_room, i_clk, i_rst_n, (fifo_push && !fifo_pop), (r_fifo_cnt < knef_pkg::FIFO_CNT_W'(knef_pkg::FIFO_DEPTH)), "result pushed into a full queue")
    `KNEF_ASSERT_IMPL(a_credit_bound, i_clk, i_rst_n, 1'b1, (credit_used <= knef_pkg::CRED_W'(knef_pkg::FIFO_DEPTH)), "results in flight exceed queue space")
    `KNEF_ASSERT_NEXT(a_flush_restart, i_clk, i_rst_n, (step && flush_done), ((r_in_col == '0) && (r_in_row == '0) && (r_fill == '0) && !r_flushing), "flush did not restart the frame")

endmodule

/* tb/knef_tb_pkg.sv */
// Edge scoreboard for the Kirsch northwest filter testbench: predicts and checks result items.
// Depends on knef_pkg for the pixel and result types, register codes and line store depth.
`timescale 1ns / 1ps

package knef_tb_pkg;
    import knef_pkg::*;

    class nw_edge_scoreboard;
        t_pix        upper_line[MAX_WIDTH];
        t_pix        middle_line[MAX_WIDTH];
        t_pix        win[3][3];
        int unsigned width_reg;
        int unsigned height_reg;
        int unsigned in_col;
        int unsigned in_row;
        int unsigned out_col;
        int unsigned out_row;
        int unsigned fill;
        bit          flushing;
        t_result     edge_q[$];
        int unsigned fail_count;

        function new();
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            fail_count = 0;
            foreach (upper_line[i]) begin
                upper_line[i]  = '0;
                middle_line[i] = '0;
            end
            foreach (win[r, c]) begin
                win[r][c] = '0;
            end
            restart_frame();
        endfunction

        function int unsigned line_len();
            if (width_reg == 0) return 1;
            if (width_reg > MAX_WIDTH) return MAX_WIDTH;
            return width_reg;
        endfunction

        function int unsigned frame_lines();
            if (height_reg == 0) return 1;
            if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
            return height_reg;
        endfunction

        function void restart_frame();
            in_col   = 0;
            in_row   = 0;
            out_col  = 0;
            out_row  = 0;
            fill     = 0;
            flushing = 1'b0;
        endfunction

        // True when no pixel is waiting for its result and the input sits at a frame start.
        function bit pipeline_empty();
            return fill == 0 && !flushing && in_col == 0 && in_row == 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_IMAGE_WIDTH) width_reg = data[CFG_WIDTH_W-1:0];
            else if (idx == REG_IMAGE_HEIGHT) height_reg = data[CFG_HEIGHT_W-1:0];
        endfunction

        // Advances the model by one accepted input item and queues the edge item, if any, that it yields.
        function void take_item(logic [CH_W-1:0] red, logic [CH_W-1:0] green,
                                logic [CH_W-1:0] blue, logic drain);
            int unsigned w, h, col, top, bot, lc, rc, sc;
            int          pos, neg, sum;
            t_pix        px, up_px, mid_px;
            t_pix        nb[3][3];
            logic [7:0]  resp[3];
            t_result     res;
            bit          last;
            w  = line_len();
            h  = frame_lines();
            px = {blue, green, red};
            if (drain) begin
                if (!flushing) begin
                    if (in_col != 0 || in_row != 0 || fill == 0) return;
                    flushing = 1'b1;
                end
                px = '0;
            end else if (flushing) begin
                restart_frame();
            end
            col    = (in_col >= MAX_WIDTH) ? MAX_WIDTH - 1 : in_col;
            up_px  = upper_line[col];
            mid_px = middle_line[col];
            if (!drain) begin
                upper_line[col]  = mid_px;
                middle_line[col] = px;
            end
            for (int r = 0; r < 3; r++) begin
                win[r][0] = win[r][1];
                win[r][1] = win[r][2];
            end
            win[0][2] = up_px;
            win[1][2] = mid_px;
            win[2][2] = px;
            if (in_col + 1 >= w) begin
                in_col = 0;
                in_row = (in_row + 1 >= h) ? 0 : in_row + 1;
            end else begin
                in_col++;
            end
            if (fill < w + 1) begin
                fill++;
                return;
            end
            // Replicate the border: rows and columns outside the frame take the centre's.
            top = (out_row == 0) ? 1 : 0;
            bot = (out_row + 1 >= h) ? 1 : 2;
            lc  = (out_col == 0) ? 1 : 0;
            rc  = (out_col + 1 >= w) ? 1 : 2;
            for (int c = 0; c < 3; c++) begin
                sc = (c == 0) ? lc : ((c == 2) ? rc : 1);
                nb[0][c] = win[top][sc];
                nb[1][c] = win[1][sc];
                nb[2][c] = win[bot][sc];
            end
            last = (out_row + 1 >= h) && (out_col + 1 >= w);
            for (int k = 0; k < 3; k++) begin
                pos = nb[0][0][8*k +: 8] + nb[0][1][8*k +: 8] + nb[1][0][8*k +: 8];
                neg = nb[0][2][8*k +: 8] + nb[1][2][8*k +: 8] + nb[2][0][8*k +: 8]
                    + nb[2][1][8*k +: 8] + nb[2][2][8*k +: 8];
                sum = 5 * pos - 3 * neg;
                if (sum < 0) sum = 0;
                if (sum > 255) sum = 255;
                resp[k] = 8'(sum);
            end
            res.edge_red   = resp[0];
            res.edge_green = resp[1];
            res.edge_blue  = resp[2];
            res.frame_last = last;
            edge_q.push_back(res);
            if (out_col + 1 >= w) begin
                out_col = 0;
                out_row = (out_row + 1 >= h) ? 0 : out_row + 1;
            end else begin
                out_col++;
            end
            if (flushing && last) restart_frame();
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (want !== got) begin
                $error("%s mismatch: expected %0d, actual %0d", name, want, got);
                fail_count++;
            end
        endfunction

        function void check_edge(logic [CH_W-1:0] red, logic [CH_W-1:0] green,
                                 logic [CH_W-1:0] blue, logic frame_last);
            t_result want;
            if (edge_q.size() == 0) begin
                $error("edge item arrived with none predicted");
                fail_count++;
                return;
            end
            want = edge_q.pop_front();
            compare_field("edge_red", want.edge_red, red);
            compare_field("edge_green", want.edge_green, green);
            compare_field("edge_blue", want.edge_blue, blue);
            compare_field("frame_last", 8'(want.frame_last), 8'(frame_last));
        endfunction
    endclass

endpackage

/* tb/tb_kirsch_northwest_edge_filter_core.sv */
// Top-level testbench of the Kirsch northwest edge filter core: drives frames, flushes and
// register writes, and checks every edge item. Depends on knef_pkg, knef_tb_pkg and the core.
`timescale 1ns / 1ps

module tb_kirsch_northwest_edge_filter_core;
    import knef_pkg::*;
    import knef_tb_pkg::*;

    // Register indexes that the core does not decode; writes to them must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    // A result passes only the pipeline registers and the result queue after the item that completes
    // it, so a short pad after the last predicted item covers anything still moving through the core.
    localparam int DRAIN_PAD    = 16;
    localparam int SETTLE_LIMIT = 4000;
    localparam int LONG_HOLD    = 300;

    logic                  i_clk        = 1'b0;
    logic                  i_rst_n      = 1'b0;
    logic                  i_cfg_valid  = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data   = '0;
    logic                  i_in_valid   = 1'b0;
    logic                  o_in_ready;
    logic [CH_W-1:0]       i_pix_red    = '0;
    logic [CH_W-1:0]       i_pix_green  = '0;
    logic [CH_W-1:0]       i_pix_blue   = '0;
    logic                  i_drain      = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_ready  = 1'b0;
    logic [CH_W-1:0]       o_edge_red;
    logic [CH_W-1:0]       o_edge_green;
    logic [CH_W-1:0]       o_edge_blue;
    logic                  o_frame_last;

    // Percentage chance, on either side, that an idle burst starts; the sender draws it per item.
    int                    idle_pct = 20;

    nw_edge_scoreboard     sb = new();

    kirsch_northwest_edge_filter_core u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_pix_red    (i_pix_red),
        .i_pix_green  (i_pix_green),
        .i_pix_blue   (i_pix_blue),
        .i_drain      (i_drain),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_edge_red   (o_edge_red),
        .o_edge_green (o_edge_green),
        .o_edge_blue  (o_edge_blue),
        .o_frame_last (o_frame_last)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // A channel level that is sometimes uniform, sometimes hard black or white and sometimes
    // dark, so that sums land in both clamps as well as in the linear range.
    function automatic logic [CH_W-1:0] rand_level();
        case ($urandom_range(2))
            0:       return 8'($urandom_range(255));
            1:       return $urandom_range(1) ? 8'hFF : 8'h00;
            default: return 8'($urandom_range(48));
        endcase
    endfunction

    // Offers one item and returns at the edge where it is taken. All drives happen at a rising
    // edge with nonblocking assignments, and the handshake is sampled at the edge, so the
    // values seen are those that were stable before it. Valid is only lowered when an idle
    // burst is wanted, never lowered and raised within the same step.
    task automatic send_item(input logic [CH_W-1:0] red, input logic [CH_W-1:0] green,
                             input logic [CH_W-1:0] blue, input logic drain);
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_pix_red   <= red;
        i_pix_green <= green;
        i_pix_blue  <= blue;
        i_drain     <= drain;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.take_item(red, green, blue, drain);
    endtask

    // Register writes leave valid high; the caller lowers it once the last write is taken.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    task automatic set_size(input logic [CFG_DATA_W-1:0] wdata,
                            input logic [CFG_DATA_W-1:0] hdata);
        if ($urandom_range(1)) begin
            cfg_write(REG_IMAGE_WIDTH, wdata);
            cfg_write(REG_IMAGE_HEIGHT, hdata);
        end else begin
            cfg_write(REG_IMAGE_HEIGHT, hdata);
            cfg_write(REG_IMAGE_WIDTH, wdata);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Drain items until the predicted frame tail has been pushed out and positions are back
    // at the start of a frame.
    task automatic flush_frame();
        while (!sb.pipeline_empty()) send_item(rand_level(), rand_level(), rand_level(), 1'b1);
    endtask

    // Waits, with a bound, for every predicted item, then lets the core run dry.
    task automatic settle();
        int unsigned waited;
        i_in_valid <= 1'b0;
        waited = 0;
        while (sb.edge_q.size() != 0 && waited < SETTLE_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (DRAIN_PAD) @(posedge i_clk);
    endtask

    // Whole frames of random pixels, with a few stray drains mixed in, joined back to back,
    // by a full flush, or by a flush that the next frame's first pixel cuts short. The phase
    // always ends with a complete flush so the next register write finds the core empty.
    task automatic run_frames(input int unsigned budget);
        int unsigned frame_len, sent;
        frame_len = sb.line_len() * sb.frame_lines();
        sent = 0;
        while (sent < budget) begin
            for (int unsigned p = 0; p < frame_len; p++) begin
                if ($urandom_range(99) < 3)
                    send_item(rand_level(), rand_level(), rand_level(), 1'b1);
                send_item(rand_level(), rand_level(), rand_level(), 1'b0);
            end
            sent += frame_len;
            case ($urandom_range(3))
                0: begin
                    // The next frame simply follows on.
                end
                1: begin
                    flush_frame();
                end
                2: begin
                    repeat ($urandom_range(1, sb.line_len()))
                        send_item(rand_level(), rand_level(), rand_level(), 1'b1);
                end
                default: begin
                    // A drain with nothing left to push out is ignored.
                    flush_frame();
                    send_item(rand_level(), rand_level(), rand_level(), 1'b1);
                end
            endcase
        end
        flush_frame();
    endtask

    // The result side: checks each accepted item and lowers ready in short random bursts.
    // Twice it holds off for a long stretch while the sender keeps offering, so that the core
    // backs up and has to stall its input.
    initial begin : result_sink
        int hold_left;
        int seen;
        hold_left = 0;
        seen      = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                sb.check_edge(o_edge_red, o_edge_green, o_edge_blue, o_frame_last);
                seen++;
                if (seen == 120 || seen == 700) hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
                hold_left = $urandom_range(0, 3);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        logic [CFG_DATA_W-1:0] wd;
        logic [CFG_DATA_W-1:0] hd;
        int unsigned           tail;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Only the width is written first, so the height still holds its reset value. A width
        // of zero acts as one, giving a single column whose frame ends after 480 lines.
        cfg_write(REG_IMAGE_WIDTH, '0);
        i_cfg_valid <= 1'b0;
        run_frames(480);
        settle();

        // Directed part on a 2x2 frame: full and empty pixels, a stray drain in mid-frame,
        // a flush, a drain with nothing pending, a back-to-back frame, and a flush cut short.
        idle_pct = 15;
        cfg_write(REG_SPARE_A, 13'($urandom_range(8191)));
        cfg_write(REG_SPARE_B, 13'($urandom_range(8191)));
        set_size(13'd2, 13'd2);
        send_item(8'h00, 8'h00, 8'h00, 1'b0);
        send_item(8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_item(8'h5A, 8'hA5, 8'hC3, 1'b1);
        send_item(8'hFF, 8'h00, 8'h80, 1'b0);
        send_item(8'h00, 8'hFF, 8'h01, 1'b0);
        flush_frame();
        send_item(8'hFF, 8'hFF, 8'hFF, 1'b1);
        // Bright upper-left corner drives the sum to its top; the inverse drives it below zero.
        send_item(8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_item(8'h00, 8'h00, 8'h00, 1'b0);
        send_item(8'h00, 8'h00, 8'h00, 1'b0);
        send_item(8'h00, 8'h00, 8'h00, 1'b0);
        send_item(8'h00, 8'h00, 8'h00, 1'b0);
        send_item(8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_item(8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_item(8'hFF, 8'hFF, 8'hFF, 1'b0);
        flush_frame();
        send_item(8'h12, 8'h34, 8'h56, 1'b0);
        send_item(8'h9A, 8'hBC, 8'hDE, 1'b0);
        send_item(8'h7F, 8'h80, 8'h01, 1'b0);
        send_item(8'hFE, 8'h02, 8'h40, 1'b0);
        send_item(8'h00, 8'h00, 8'h00, 1'b1);
        send_item(8'h33, 8'hCC, 8'h0F, 1'b0);
        send_item(8'hF0, 8'h55, 8'hAA, 1'b0);
        send_item(8'h01, 8'hFE, 8'h80, 1'b0);
        send_item(8'hC0, 8'h3F, 8'h99, 1'b0);
        flush_frame();
        settle();

        // Random phases over small frames, each with its own mix of idling.
        for (int ph = 0; ph < 10; ph++) begin
            case ($urandom_range(2))
                0:       idle_pct = 0;
                1:       idle_pct = 15;
                default: idle_pct = 40;
            endcase
            wd = ($urandom_range(3) == 0) ? 13'($urandom_range(7, 40)) : 13'($urandom_range(6));
            hd = 13'($urandom_range(5));
            set_size(wd, hd);
            run_frames(70);
            settle();
        end

        // The largest frame, with no idling: both registers written with all bits set, which
        // the core takes as the full line store width and its deepest frame. Only part of the
        // first line is sent, so the core must hold back every result.
        idle_pct = 0;
        set_size(13'h1FFF, 13'h1FFF);
        tail = $urandom_range(180, 220);
        for (int unsigned p = 0; p < tail; p++) begin
            if ($urandom_range(99) < 2)
                send_item(rand_level(), rand_level(), rand_level(), 1'b1);
            send_item(rand_level(), rand_level(), rand_level(), 1'b0);
        end
        settle();

        if (sb.edge_q.size() != 0) begin
            $error("%0d predicted edge items never arrived", sb.edge_q.size());
            sb.fail_count++;
        end
        if (sb.fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Guard against a hung handshake; this is several times the slowest correct run.
    initial begin : watchdog
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
